// ===== src/bvf_pkg.sv =====
// Shared constants, calibration table and helper for the battery voltage filter.
// No dependencies; imported by battery_voltage_filter_soc and both test modules.
package bvf_pkg;

  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int SP_W       = 8;
  localparam int OP_W       = 2;
  localparam int TABLE_ROWS = 21;
  localparam int EMA_SHIFT  = 2;
  localparam int FRAC_BITS  = 8;
  localparam int EMA_W      = MV_W + FRAC_BITS;
  localparam int ROW_W      = $clog2(TABLE_ROWS);
  localparam int HCNT_W     = 2;
  localparam int DEN_W      = MV_W + 1;
  localparam int PROD_W     = MV_W + PCT_W;
  localparam int REM_W      = PROD_W + 2;
  localparam int DSH_W      = DEN_W + PCT_W - 1;
  localparam int QCNT_W     = $clog2(PCT_W);

  localparam logic [OP_W-1:0]   OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0]   OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0]   OP_SEED   = 2'd2;

  localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
  localparam logic [HCNT_W-1:0] HIST_FULL = 2'd3;

  // Discharge curve, highest voltage first.
  localparam logic [MV_W-1:0] SOC_MV [TABLE_ROWS] = '{
    16'd4200, 16'd4150, 16'd4110, 16'd4080, 16'd4020, 16'd3980, 16'd3950,
    16'd3910, 16'd3870, 16'd3850, 16'd3840, 16'd3820, 16'd3800, 16'd3790,
    16'd3770, 16'd3750, 16'd3730, 16'd3710, 16'd3690, 16'd3610, 16'd3500
  };
  localparam logic [PCT_W-1:0] SOC_PCT [TABLE_ROWS] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  function automatic logic [MV_W-1:0] median3(input logic [MV_W-1:0] a,
                                               input logic [MV_W-1:0] b,
                                               input logic [MV_W-1:0] c);
    logic [MV_W-1:0] m;
    if (a > b) begin
      if (b > c) m = b;
      else m = (a > c) ? c : a;
    end else begin
      if (a > c) m = a;
      else m = (b > c) ? c : b;
    end
    return m;
  endfunction

endpackage

// ===== src/battery_voltage_filter_soc.sv =====
// Battery voltage filter and state-of-charge estimator, top level.
// Depends on bvf_pkg (widths, opcodes, discharge table, median helper).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: push a sample,
//   query the percent, or seed the state. Each request yields exactly one
//   result on the output channel (out_valid/out_ready): the filtered voltage
//   and the percent after the request.
//   Push, seed and unused opcode go from ST_APPLY to ST_OUT (for a push,
//   history shift, median and EMA update run in one step).
//   Query: ST_QCHK goes straight to ST_FIN when the voltage is at or beyond
//   either end of the table. Else a single magnitude comparator walks the
//   table one row a cycle (up to 20 rows), then one 16x7 multiply and a
//   restoring divider giving one quotient bit a cycle interpolate.
//   in_ready is high only while the sequencer is idle, so one request is in
//   flight at a time; the next request is taken only once the sequencer is
//   back in idle after writing the result, so for queries the sustained rate is set by the table walk and divider.
//   The result sits in an output register: a new request is taken while an
//   earlier result still waits. A stalled receiver holds the result and, once
//   the next request is done, stalls the sequencer before it writes again.
//   Reset (rst_n low, synchronous) clears history, EMA, percent memory and
//   both handshakes.
module battery_voltage_filter_soc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bvf_pkg::OP_W-1:0]    in_opcode,
  input  logic [bvf_pkg::MV_W-1:0]    in_sample_mv,
  input  logic [bvf_pkg::SP_W-1:0]    in_seed_pct,
  input  logic                        in_usb_powered,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bvf_pkg::MV_W-1:0]    out_filtered_mv,
  output logic [bvf_pkg::PCT_W-1:0]   out_percent
);
  import bvf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_APPLY, ST_QCHK, ST_WALK, ST_MUL, ST_DVI, ST_DIV, ST_FIN, ST_OUT
  } st_t;

  st_t               state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [MV_W-1:0]   mv_r, mv_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              usb_r, usb_nxt;
  logic [MV_W-1:0]   hist0_r, hist0_nxt, hist1_r, hist1_nxt, hist2_r, hist2_nxt;
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [EMA_W-1:0]  ema_r, ema_nxt;
  logic              primed_r, primed_nxt;
  logic              have_r, have_nxt;
  logic [PCT_W-1:0]  last_pct_r, last_pct_nxt;
  logic [ROW_W-1:0]  idx_r, idx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [PCT_W-1:0]  q_r, q_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PCT_W-1:0]  calc_pct_r, calc_pct_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]   out_mv_r, out_mv_nxt;
  logic [PCT_W-1:0]  out_pct_r, out_pct_nxt;

  logic [EMA_W:0]    rnd;
  logic [EMA_W-FRAC_BITS:0] rnd_sh;
  logic [MV_W-1:0]   fmv;
  logic [MV_W-1:0]   row_mv, prev_mv, span;
  logic [PCT_W-1:0]  row_pct, dp;
  logic [MV_W-1:0]   med;
  logic [EMA_W-1:0]  med_q;
  logic signed [EMA_W:0] diff, step;
  logic [HCNT_W-1:0] hcnt_inc;
  logic              q_bit;
  logic [PCT_W-1:0]  q_fin;
  logic [PCT_W:0]    pct_sum;
  logic [PCT_W-1:0]  pct_clamped;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_filtered_mv = out_mv_r;
  assign out_percent     = out_pct_r;

  // Filtered millivolts: round to nearest, saturate.
  assign rnd    = {1'b0, ema_r} + (EMA_W+1)'(1 << (FRAC_BITS - 1));
  assign rnd_sh = rnd[EMA_W:FRAC_BITS];
  assign fmv    = rnd_sh[EMA_W-FRAC_BITS] ? {MV_W{1'b1}} : rnd_sh[MV_W-1:0];

  // Shared table row operands for the walk, multiply and divider.
  assign row_mv  = SOC_MV[idx_r];
  assign prev_mv = SOC_MV[idx_r - ROW_W'(1)];
  assign row_pct = SOC_PCT[idx_r];
  assign dp      = SOC_PCT[idx_r - ROW_W'(1)] - row_pct;
  assign span    = prev_mv - row_mv;

  // Push path: new history is {mv, hist0, hist1}.
  assign hcnt_inc = (hcnt_r == HIST_FULL) ? hcnt_r : hcnt_r + HCNT_W'(1);
  assign med      = (hcnt_inc != HIST_FULL) ? mv_r : median3(mv_r, hist0_r, hist1_r);
  assign med_q    = {med, {FRAC_BITS{1'b0}}};
  assign diff     = $signed({1'b0, med_q}) - $signed({1'b0, ema_r});
  assign step     = diff >>> EMA_SHIFT;

  // Divider step and final interpolation sum.
  assign q_bit       = (rem_r >= REM_W'(dsh_r));
  assign q_fin       = {q_r[PCT_W-2:0], q_bit};
  assign pct_sum     = {1'b0, row_pct} + {1'b0, q_fin};
  assign pct_clamped = (pct_sum > {1'b0, PCT_MAX}) ? PCT_MAX : pct_sum[PCT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    mv_nxt        = mv_r;
    sp_nxt        = sp_r;
    usb_nxt       = usb_r;
    hist0_nxt     = hist0_r;
    hist1_nxt     = hist1_r;
    hist2_nxt     = hist2_r;
    hcnt_nxt      = hcnt_r;
    ema_nxt       = ema_r;
    primed_nxt    = primed_r;
    have_nxt      = have_r;
    last_pct_nxt  = last_pct_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    calc_pct_nxt  = calc_pct_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_mv_nxt    = out_mv_r;
    out_pct_nxt   = out_pct_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_opcode;
          mv_nxt  = in_sample_mv;
          sp_nxt  = in_seed_pct;
          usb_nxt = in_usb_powered;
          state_nxt = (in_opcode == OP_QUERY) ? ST_QCHK : ST_APPLY;
        end
      end
      ST_APPLY: begin
        case (op_r)
          OP_PUSH: begin
            hist0_nxt  = mv_r;
            hist1_nxt  = hist0_r;
            hist2_nxt  = hist1_r;
            hcnt_nxt   = hcnt_inc;
            primed_nxt = 1'b1;
            if (!primed_r) ema_nxt = med_q;
            else ema_nxt = EMA_W'($signed({1'b0, ema_r}) + step);
          end
          OP_SEED: begin
            hist0_nxt    = mv_r;
            hist1_nxt    = mv_r;
            hist2_nxt    = mv_r;
            hcnt_nxt     = HIST_FULL;
            ema_nxt      = {mv_r, {FRAC_BITS{1'b0}}};
            primed_nxt   = 1'b1;
            have_nxt     = 1'b1;
            last_pct_nxt = (sp_r > SP_W'(PCT_MAX)) ? PCT_MAX : sp_r[PCT_W-1:0];
          end
          default: ;
        endcase
        state_nxt = ST_OUT;
      end
      ST_QCHK: begin
        idx_nxt = ROW_W'(1);
        if (fmv >= SOC_MV[0]) begin
          calc_pct_nxt = PCT_MAX;
          state_nxt    = ST_FIN;
        end else if (fmv <= SOC_MV[TABLE_ROWS-1]) begin
          calc_pct_nxt = '0;
          state_nxt    = ST_FIN;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (fmv >= row_mv) begin
          if (span == '0) begin
            calc_pct_nxt = row_pct;
            state_nxt    = ST_FIN;
          end else begin
            state_nxt = ST_MUL;
          end
        end else begin
          idx_nxt = idx_r + ROW_W'(1);
        end
      end
      ST_MUL: begin
        prod_nxt  = (fmv - row_mv) * dp;
        state_nxt = ST_DVI;
      end
      ST_DVI: begin
        rem_nxt   = {prod_r, 1'b0} + REM_W'(span);
        den_nxt   = {span, 1'b0};
        dsh_nxt   = {span, 1'b0, {(PCT_W-1){1'b0}}};
        q_nxt     = '0;
        cnt_nxt   = QCNT_W'(PCT_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (q_bit) rem_nxt = rem_r - REM_W'(dsh_r);
        dsh_nxt = dsh_r >> 1;
        q_nxt   = q_fin;
        cnt_nxt = cnt_r - QCNT_W'(1);
        if (cnt_r == '0) begin
          calc_pct_nxt = pct_clamped;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        // Percent may only fall while on battery.
        if (!usb_r && have_r && (calc_pct_r > last_pct_r)) last_pct_nxt = last_pct_r;
        else last_pct_nxt = calc_pct_r;
        have_nxt  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mv_nxt    = fmv;
          out_pct_nxt   = last_pct_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hist0_r     <= '0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      hcnt_r      <= '0;
      ema_r       <= '0;
      primed_r    <= 1'b0;
      have_r      <= 1'b0;
      last_pct_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist0_r     <= hist0_nxt;
      hist1_r     <= hist1_nxt;
      hist2_r     <= hist2_nxt;
      hcnt_r      <= hcnt_nxt;
      ema_r       <= ema_nxt;
      primed_r    <= primed_nxt;
      have_r      <= have_nxt;
      last_pct_r  <= last_pct_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    mv_r       <= mv_nxt;
    sp_r       <= sp_nxt;
    usb_r      <= usb_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    dsh_r      <= dsh_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    calc_pct_r <= calc_pct_nxt;
    out_mv_r   <= out_mv_nxt;
    out_pct_r  <= out_pct_nxt;
  end

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_pct_r <= PCT_MAX)
    else $error("stored percent above full scale");

  a_walk_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (idx_r != '0) && (idx_r < ROW_W'(TABLE_ROWS)))
    else $error("table walk row out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == '0) |=> (rem_r < REM_W'(den_r)))
    else $error("divider remainder not below divisor");

  a_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && !usb_r && have_r |=> last_pct_r <= $past(last_pct_r))
    else $error("percent rose without external power");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_APPLY) |=> $stable(hist0_r) && $stable(ema_r))
    else $error("filter state changed outside apply step");

endmodule

// ===== test/soc_result_monitor.sv =====
// Result monitor for battery_voltage_filter_soc: watches both channels, predicts each result
// from its own model of the median/EMA filter and the charge table, and compares it.
// Depends on bvf_pkg for widths, opcodes and the discharge table.
module soc_result_monitor (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [bvf_pkg::OP_W-1:0]  in_opcode,
  input  logic [bvf_pkg::MV_W-1:0]  in_sample_mv,
  input  logic [bvf_pkg::SP_W-1:0]  in_seed_pct,
  input  logic                      in_usb_powered,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [bvf_pkg::MV_W-1:0]  out_filtered_mv,
  input  logic [bvf_pkg::PCT_W-1:0] out_percent,
  output int                        mismatches,
  output int                        outstanding
);
  import bvf_pkg::*;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } soc_reading_t;

  soc_reading_t      reading_q[$];

  logic [MV_W-1:0]   hist [3];
  logic [HCNT_W-1:0] hist_cnt;
  logic [EMA_W-1:0]  ema;
  logic              primed;
  logic              have_pct;
  logic [PCT_W-1:0]  last_pct;

  task automatic flag(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [MV_W-1:0] mid_of_three(input logic [MV_W-1:0] a,
                                                   input logic [MV_W-1:0] b,
                                                   input logic [MV_W-1:0] c);
    logic [MV_W-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return lo;
    if (c > hi) return hi;
    return c;
  endfunction

  function automatic logic [MV_W-1:0] rounded_mv(input logic [EMA_W-1:0] e);
    logic [EMA_W:0] r;
    r = ({1'b0, e} + (EMA_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    return (r > (EMA_W+1)'(16'hFFFF)) ? 16'hFFFF : r[MV_W-1:0];
  endfunction

  // linear interpolation between table rows, rounded half up
  function automatic logic [PCT_W-1:0] charge_from_mv(input logic [MV_W-1:0] mv);
    logic [PCT_W-1:0] pct;
    bit               found;
    int               span, dp, v;
    pct   = '0;
    found = 0;
    if (mv >= SOC_MV[0]) begin
      pct = PCT_MAX;
    end else if (mv > SOC_MV[TABLE_ROWS-1]) begin
      for (int i = 1; i < TABLE_ROWS; i++) begin
        if (!found && mv >= SOC_MV[i]) begin
          found = 1;
          span  = int'(SOC_MV[i-1]) - int'(SOC_MV[i]);
          dp    = int'(SOC_PCT[i-1]) - int'(SOC_PCT[i]);
          v     = int'(SOC_PCT[i]) + ((int'(mv) - int'(SOC_MV[i])) * dp * 2 + span) / (2 * span);
          pct   = (v > int'(PCT_MAX)) ? PCT_MAX : PCT_W'(v);
        end
      end
    end
    return pct;
  endfunction

  function automatic soc_reading_t advance_gauge(input logic [OP_W-1:0] op,
                                                 input logic [MV_W-1:0] mv,
                                                 input logic [SP_W-1:0] sp,
                                                 input logic usb);
    soc_reading_t             res;
    logic [MV_W-1:0]          med;
    logic signed [EMA_W+1:0]  diff, step;
    logic [PCT_W-1:0]         p;
    res.pct = last_pct;
    case (op)
      OP_PUSH: begin
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = mv;
        if (hist_cnt < HIST_FULL) hist_cnt++;
        med = (hist_cnt < HIST_FULL) ? mv : mid_of_three(hist[0], hist[1], hist[2]);
        if (!primed) begin
          ema    = {med, {FRAC_BITS{1'b0}}};
          primed = 1'b1;
        end else begin
          diff = $signed({2'b00, med, {FRAC_BITS{1'b0}}}) - $signed({2'b00, ema});
          step = diff >>> EMA_SHIFT;
          ema  = ema + step[EMA_W-1:0];
        end
      end
      OP_QUERY: begin
        p = charge_from_mv(rounded_mv(ema));
        if (!usb && have_pct && p > last_pct) p = last_pct;
        last_pct = p;
        have_pct = 1'b1;
        res.pct  = p;
      end
      OP_SEED: begin
        hist[0]  = mv;
        hist[1]  = mv;
        hist[2]  = mv;
        hist_cnt = HIST_FULL;
        ema      = {mv, {FRAC_BITS{1'b0}}};
        primed   = 1'b1;
        last_pct = (sp > SP_W'(PCT_MAX)) ? PCT_MAX : sp[PCT_W-1:0];
        have_pct = 1'b1;
        res.pct  = last_pct;
      end
      default: ;
    endcase
    res.mv = rounded_mv(ema);
    return res;
  endfunction

  always @(posedge clk) begin
    soc_reading_t want;
    if (!rst_n) begin
      reading_q.delete();
      hist[0]    = '0;
      hist[1]    = '0;
      hist[2]    = '0;
      hist_cnt   = '0;
      ema        = '0;
      primed     = 1'b0;
      have_pct   = 1'b0;
      last_pct   = '0;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          flag("result with no request outstanding, filtered_mv", out_filtered_mv, 0);
        end else begin
          want = reading_q.pop_front();
          if (out_filtered_mv !== want.mv) flag("filtered_mv", out_filtered_mv, want.mv);
          if (out_percent !== want.pct) flag("percent", out_percent, want.pct);
        end
      end
      if (in_valid && in_ready)
        reading_q.push_back(advance_gauge(in_opcode, in_sample_mv, in_seed_pct, in_usb_powered));
    end
    outstanding <= reading_q.size();
  end

endmodule

// ===== test/tb_battery_voltage_filter_soc.sv =====
// Testbench top for battery_voltage_filter_soc: directed and random push/query/seed/unused requests
// under several idle and stall patterns; the verdict comes from soc_result_monitor.
// Depends on bvf_pkg, battery_voltage_filter_soc and soc_result_monitor.
module tb_battery_voltage_filter_soc;
  import bvf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int              CYCLE_LIMIT  = 500000;
  localparam int              RANDOM_ITEMS = 900;
  localparam int              DRAIN_CYCLES = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_opcode;
  logic [MV_W-1:0]   in_sample_mv;
  logic [SP_W-1:0]   in_seed_pct;
  logic              in_usb_powered;
  logic              out_valid;
  logic              out_ready;
  logic [MV_W-1:0]   out_filtered_mv;
  logic [PCT_W-1:0]  out_percent;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_cnt      = 0;
  int mismatch_cnt;
  int pending_cnt;

  battery_voltage_filter_soc dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_sample_mv    (in_sample_mv),
    .in_seed_pct     (in_seed_pct),
    .in_usb_powered  (in_usb_powered),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_filtered_mv (out_filtered_mv),
    .out_percent     (out_percent)
  );

  soc_result_monitor mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_sample_mv    (in_sample_mv),
    .in_seed_pct     (in_seed_pct),
    .in_usb_powered  (in_usb_powered),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_filtered_mv (out_filtered_mv),
    .out_percent     (out_percent),
    .mismatches      (mismatch_cnt),
    .outstanding     (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [MV_W-1:0] mv,
                          input logic [SP_W-1:0] sp, input logic usb);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_sample_mv <= MV_W'($urandom);
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_sample_mv   <= mv;
    in_seed_pct    <= sp;
    in_usb_powered <= usb;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // mostly in-range voltages so the table walk is exercised, some row edges and full range
  task automatic send_random_req();
    int               r, s;
    logic [OP_W-1:0]  op;
    logic [MV_W-1:0]  mv;
    r = $urandom_range(99, 0);
    s = $urandom_range(99, 0);
    if (r < 50)      op = OP_PUSH;
    else if (r < 80) op = OP_QUERY;
    else if (r < 92) op = OP_SEED;
    else if (r < 96) op = OP_UNUSED;
    else             op = OP_W'($urandom);
    if (s < 72)      mv = MV_W'($urandom_range(4300, 3400));
    else if (s < 84) mv = MV_W'(SOC_MV[$urandom_range(TABLE_ROWS-1, 0)] + $urandom_range(2, 0) - 1);
    else if (s < 96) mv = MV_W'($urandom);
    else             mv = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    send_req(op, mv, SP_W'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_PUSH;
    in_sample_mv   <= '0;
    in_seed_pct    <= '0;
    in_usb_powered <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(OP_QUERY,  16'd0,     8'd0,   1'b0);
    send_req(OP_PUSH,   16'd4000,  8'd0,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b1);
    send_req(OP_PUSH,   16'd3600,  8'd0,   1'b0);
    send_req(OP_PUSH,   16'd4300,  8'd0,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b0);
    send_req(OP_PUSH,   16'd0,     8'd0,   1'b0);
    send_req(OP_PUSH,   16'hFFFF,  8'd0,   1'b0);
    send_req(OP_PUSH,   16'hFFFF,  8'd0,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b0);
    send_req(OP_SEED,   16'd4200,  8'd255, 1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b0);
    send_req(OP_SEED,   16'd3500,  8'd0,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b0);
    send_req(OP_SEED,   16'd3850,  8'd7,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b1);
    send_req(OP_SEED,   16'd4175,  8'd101, 1'b1);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b1);
    send_req(OP_SEED,   16'hFFFF,  8'd128, 1'b1);
    send_req(OP_UNUSED, 16'h5A5A,  8'hA5,  1'b1);
    send_req(OP_PUSH,   16'd0,     8'd0,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b1);
    send_req(OP_SEED,   16'd3501,  8'd1,   1'b0);
    send_req(OP_QUERY,  16'd0,     8'd0,   1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (RANDOM_ITEMS / 4) send_random_req();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
